// ===== rtl/core/audio_channel_matrix_mixer_core_defines.svh =====
// Assertion macros shared by the mixer RTL.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef AUDIO_CHANNEL_MATRIX_MIXER_CORE_DEFINES_SVH
`define AUDIO_CHANNEL_MATRIX_MIXER_CORE_DEFINES_SVH

// Checked on every clock edge once reset has been released.
`define ACMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ACMM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/acmm_pkg.sv =====
// Shared types, constants and helpers for the channel matrix mixer.
// Depends on nothing; used by every module of the mixer.
`default_nettype none

package acmm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_LIMIT     = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;

  localparam int IDX_W      = 3;
  localparam int CNT_W      = 4;
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_IN_W  = 17;
  localparam int GAIN_W     = 16;
  localparam int GADDR_W    = 2 * IDX_W;
  localparam int GAIN_DEPTH = 1 << GADDR_W;
  localparam int FB_DEPTH   = 1 << IDX_W;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W      = PROD_W + IDX_W;
  localparam int FRAC_SHIFT = 15;
  localparam int Y_W        = ACC_W - FRAC_SHIFT;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH = 8;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

  localparam logic REG_IN_CHANNELS  = 1'b0;
  localparam logic REG_OUT_CHANNELS = 1'b1;

  localparam logic [CNT_W-1:0] CH_RESET = 4'd2;

  typedef struct packed {
    logic                       is_gain;
    logic signed [SAMPLE_W-1:0] sample;
    logic [GADDR_W-1:0]         gaddr;
    logic [GAIN_W-1:0]          gain;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic [IDX_W-1:0]           out_channel;
    logic                       last;
  } res_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r);
    logic [CNT_W-1:0] n;
    n = r;
    if (n == '0) n = CNT_W'(1);
    if (n > CNT_W'(CH_LIMIT)) n = CNT_W'(CH_LIMIT);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acmm_front.sv =====
// Input side of the mixer: accepts words, clamps gains and queues commands.
// Depends on acmm_pkg.
`default_nettype none

module acmm_front import acmm_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic                        kind_i,
  input  wire logic signed [SAMPLE_W-1:0]  sample_i,
  input  wire logic [IDX_W-1:0]            gain_row_i,
  input  wire logic [IDX_W-1:0]            gain_col_i,
  input  wire logic signed [GAIN_IN_W-1:0] gain_value_i,
  output logic                             cmd_valid_o,
  output cmd_t                             cmd_o,
  input  wire logic                        cmd_pop_i
);

  cmd_t                cq_mem_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_PTR_W:0]   cnt_q, cnt_d;
  logic                wr_en;
  logic                rd_en;
  cmd_t                cmd_new;
  logic [GAIN_W-1:0]   gain_clamped;

  always_comb begin
    if (gain_value_i[GAIN_IN_W-1]) begin
      gain_clamped = '0;
    end else if (gain_value_i[GAIN_W-1:0] > GAIN_ONE) begin
      gain_clamped = GAIN_ONE;
    end else begin
      gain_clamped = gain_value_i[GAIN_W-1:0];
    end
    cmd_new.is_gain = kind_i;
    cmd_new.sample  = sample_i;
    cmd_new.gaddr   = {gain_row_i, gain_col_i};
    cmd_new.gain    = gain_clamped;
  end

  assign full_o      = (cnt_q == (CQ_PTR_W + 1)'(CQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cq_mem_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + CQ_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + CQ_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + (CQ_PTR_W + 1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - (CQ_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cq_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/acmm_back.sv =====
// Execution side of the mixer: gain matrix, frame buffer and the shared
// multiply-accumulate sequencer. Depends on acmm_pkg and the assertion macros.
`default_nettype none
`include "audio_channel_matrix_mixer_core_defines.svh"

module acmm_back import acmm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire cmd_t             cmd_i,
  output logic                  cmd_pop_o,
  input  wire logic [CNT_W-1:0] in_channels_i,
  input  wire logic [CNT_W-1:0] out_channels_i,
  input  wire logic             res_full_i,
  output logic                  res_push_o,
  output res_t                  res_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] nin, nout;
  logic             frame_done;
  logic             k_last;
  logic             j_last;

  logic [GAIN_W-1:0]   gmem [GAIN_DEPTH];
  logic [GAIN_DEPTH-1:0] gval_q;
  logic                gwr;
  logic [GADDR_W-1:0]  rd_addr;
  logic [GAIN_W-1:0]   g_rd_q;
  logic                gv_rd_q;
  logic [GAIN_W-1:0]   g_eff;

  logic signed [SAMPLE_W-1:0] fb_q [FB_DEPTH];
  logic                       fb_wr;
  logic signed [SAMPLE_W-1:0] s_rd_q;

  logic                     issue;
  logic                     p1_v_q, p1_last_q;
  logic                     p2_v_q, p2_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     acc_clr;

  logic signed [ACC_W-1:0]    rnd;
  logic signed [Y_W-1:0]      y;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign nin        = eff_count(in_channels_i);
  assign nout       = eff_count(out_channels_i);
  assign frame_done = (({1'b0, pos_q} + CNT_W'(1)) >= nin);
  assign k_last     = (({1'b0, k_q} + CNT_W'(1)) == nin);
  assign j_last     = (({1'b0, j_q} + CNT_W'(1)) == nout);

  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;
  assign gwr       = cmd_pop_o && cmd_i.is_gain;
  assign fb_wr     = cmd_pop_o && !cmd_i.is_gain;
  assign issue     = (st_q == ST_MAC);
  assign rd_addr   = {j_q, k_q};
  assign acc_clr   = (st_q == ST_WAIT) && !res_full_i;
  assign g_eff     = gv_rd_q ? g_rd_q : '0;

  always_comb begin
    st_d  = st_q;
    pos_d = pos_q;
    j_d   = j_q;
    k_d   = k_q;
    case (st_q)
      ST_IDLE: begin
        if (fb_wr) begin
          if (frame_done) begin
            pos_d = '0;
            j_d   = '0;
            st_d  = ST_WAIT;
          end else begin
            pos_d = pos_q + IDX_W'(1);
          end
        end
      end
      ST_WAIT: begin
        if (!res_full_i) begin
          k_d  = '0;
          st_d = ST_MAC;
        end
      end
      ST_MAC: begin
        k_d = k_q + IDX_W'(1);
        if (k_last) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (p2_v_q && p2_last_q) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (j_last) begin
          st_d = ST_IDLE;
        end else begin
          j_d  = j_q + IDX_W'(1);
          st_d = ST_WAIT;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      pos_q     <= '0;
      j_q       <= '0;
      k_q       <= '0;
      gval_q    <= '0;
      p1_v_q    <= 1'b0;
      p1_last_q <= 1'b0;
      p2_v_q    <= 1'b0;
      p2_last_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      pos_q     <= pos_d;
      j_q       <= j_d;
      k_q       <= k_d;
      p1_v_q    <= issue;
      p1_last_q <= issue && k_last;
      p2_v_q    <= p1_v_q;
      p2_last_q <= p1_last_q;
      if (gwr) begin
        gval_q[cmd_i.gaddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (gwr) begin
      gmem[cmd_i.gaddr] <= cmd_i.gain;
    end
    g_rd_q  <= gmem[rd_addr];
    gv_rd_q <= gval_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fb_wr) begin
      fb_q[pos_q] <= cmd_i.sample;
    end
    s_rd_q <= fb_q[k_q];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(s_rd_q) * PROD_W'($signed({1'b0, g_eff}));
    if (acc_clr) begin
      acc_q <= '0;
    end else if (p2_v_q) begin
      acc_q <= acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_comb begin
    rnd = acc_q + ACC_W'(1 << (FRAC_SHIFT - 1));
    y   = rnd[ACC_W-1:FRAC_SHIFT];
    if (y > Y_W'(SAMPLE_MAX)) begin
      y_sat = SAMPLE_MAX;
    end else if (y < Y_W'(SAMPLE_MIN)) begin
      y_sat = SAMPLE_MIN;
    end else begin
      y_sat = y[SAMPLE_W-1:0];
    end
  end

  assign res_push_o         = (st_q == ST_FIN);
  assign res_o.mixed_sample = y_sat;
  assign res_o.out_channel  = j_q;
  assign res_o.last         = j_last;

  `ACMM_ASSERT(a_pop_only_idle, cmd_pop_o |-> (st_q == ST_IDLE) && cmd_valid_i, "Pop while busy")
  `ACMM_ASSERT(a_push_has_room, res_push_o |-> !res_full_i, "Result pushed into a full queue")
  `ACMM_ASSERT(a_tap_in_range, issue |-> ({1'b0, k_q} < nin), "Tap index beyond input count")
  `ACMM_ASSERT(a_last_ends_frame, res_push_o && res_o.last |=> (st_q == ST_IDLE), "Frame overran")
  `ACMM_ASSERT(a_drain_done, p2_v_q && p2_last_q |-> (st_q == ST_DRAIN), "Late final product")

endmodule

`default_nettype wire

// ===== rtl/core/acmm_res_fifo.sv =====
// Result queue between the accumulator and the output ports.
// Depends on acmm_pkg.
`default_nettype none

module acmm_res_fifo import acmm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      full_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output res_t      data_o
);

  res_t                rq_mem_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RQ_PTR_W:0]   cnt_q, cnt_d;
  logic                wr_en;
  logic                rd_en;

  assign full_o  = (cnt_q == (RQ_PTR_W + 1)'(RQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = rq_mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + (RQ_PTR_W + 1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - (RQ_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rq_mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/audio_channel_matrix_mixer_core.sv =====
// Gain words and samples enter a two-deep command queue, one word per cycle while it is
// not full; the back end pops commands only while idle. The sample completing a frame
// starts the mix, and the results for the output channels are computed one after another
// by the single shared multiply-accumulate.
// Reset: asynchronous, active low; queues empty, gain matrix reads as zero, frame position
// zero, both channel counts 2. Depends on acmm_pkg, acmm_front, acmm_back, acmm_res_fifo.
`default_nettype none

module audio_channel_matrix_mixer_core import acmm_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        kind_i,
  input  wire logic signed [SAMPLE_W-1:0]  sample_i,
  input  wire logic [IDX_W-1:0]            gain_row_i,
  input  wire logic [IDX_W-1:0]            gain_col_i,
  input  wire logic signed [GAIN_IN_W-1:0] gain_value_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [SAMPLE_W-1:0]       mixed_sample_o,
  output logic [IDX_W-1:0]                 out_channel_o,
  output logic                             last_o
);

  logic [CNT_W-1:0] in_ch_q, out_ch_q;
  logic             cfg_wr;
  logic             reg_sel;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  res_t             res_in;
  res_t             res_out;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= CH_RESET;
      out_ch_q <= CH_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_IN_CHANNELS:  in_ch_q  <= pwdata[CNT_W-1:0];
        REG_OUT_CHANNELS: out_ch_q <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IN_CHANNELS:  prdata = {{(32 - CNT_W){1'b0}}, in_ch_q};
      REG_OUT_CHANNELS: prdata = {{(32 - CNT_W){1'b0}}, out_ch_q};
      default:          prdata = '0;
    endcase
  end

  acmm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .kind_i       (kind_i),
    .sample_i     (sample_i),
    .gain_row_i   (gain_row_i),
    .gain_col_i   (gain_col_i),
    .gain_value_i (gain_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  acmm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .in_channels_i  (in_ch_q),
    .out_channels_i (out_ch_q),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_o          (res_in)
  );

  acmm_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_out)
  );

  assign mixed_sample_o = res_out.mixed_sample;
  assign out_channel_o  = res_out.out_channel;
  assign last_o         = res_out.last;

endmodule

`default_nettype wire
